/* sv/dltq_pkg.sv */
// Shared types, codes and sizes of the delta-list timer queue.
`default_nettype none
package dltq_pkg;

  // Table size default and fixed field widths
  localparam int unsigned NUM_SLOTS_DEF = 16;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned HANDLE_W      = 16;
  localparam int unsigned DELAY_W       = 32;
  localparam int unsigned SLOT_OUT_W    = 5;
  localparam int unsigned QDEPTH        = 2;

  // Command codes as they arrive on the input channel
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DISP = 2'd2;

  // Classified operations handed from front to back
  typedef logic [1:0] op_t;
  localparam op_t OP_TICK = 2'd0;
  localparam op_t OP_ADD  = 2'd1;
  localparam op_t OP_DISP = 2'd2;
  localparam op_t OP_NOP  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [HANDLE_W-1:0] task_handle;
    logic [DELAY_W-1:0]  first_delay;
    logic [DELAY_W-1:0]  repeat_period;
  } in_beat_t;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot_index;
    logic                  fired;
    logic [HANDLE_W-1:0]   fired_handle;
  } out_beat_t;

  // Queue entry between the front and the back
  typedef struct packed {
    op_t                 op;
    logic [HANDLE_W-1:0] handle;
    logic [DELAY_W-1:0]  delay;
    logic [DELAY_W-1:0]  period;
  } q_entry_t;

endpackage
`default_nettype wire

/* sv/dltq_front.sv */
// Front end: accepts command beats, classifies them and queues them for the back end.
`default_nettype none
module dltq_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  dltq_pkg::in_beat_t   in_data,
  output logic                 q_valid,
  output dltq_pkg::q_entry_t   q_head,
  input  wire                  q_pop
);
  import dltq_pkg::*;

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  q_entry_t             q_mem [QDEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]     count_r;
  q_entry_t             entry;
  logic                 push;

  // Classify the command; fields a command does not use are cleared
  always_comb begin
    entry = '0;
    case (in_data.command)
      CMD_TICK: entry.op = OP_TICK;
      CMD_ADD: begin
        entry.op     = OP_ADD;
        entry.handle = in_data.task_handle;
        entry.delay  = in_data.first_delay;
        entry.period = in_data.repeat_period;
      end
      CMD_DISP: entry.op = OP_DISP;
      default:  entry.op = OP_NOP;
    endcase
  end

  assign in_stall = (count_r == CNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_head   = q_mem[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= entry;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && q_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/dltq_back.sv */
// Back end: slot table, delta-list walk sequencer and result register.
`default_nettype none
module dltq_back #(
  parameter int unsigned NUM_SLOTS = dltq_pkg::NUM_SLOTS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_valid,
  input  dltq_pkg::q_entry_t   q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output dltq_pkg::out_beat_t  out_data
);
  import dltq_pkg::*;

  localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned IDX_W  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned SUM_W  = DELAY_W + SLOT_W + 1;
  localparam logic [IDX_W-1:0] NULL_CODE = IDX_W'(NUM_SLOTS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_UNLINK = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  // Slot table
  logic [NUM_SLOTS-1:0] in_use_r;
  logic [HANDLE_W-1:0]  handle_mem [NUM_SLOTS];
  logic [DELAY_W-1:0]   delay_mem  [NUM_SLOTS];
  logic [DELAY_W-1:0]   period_mem [NUM_SLOTS];
  logic [IDX_W-1:0]     succ_mem   [NUM_SLOTS];
  logic [IDX_W-1:0]     head_r;

  // Sequencer state
  logic [2:0]           state_r;
  op_t                  op_r;
  logic [HANDLE_W-1:0]  hd_r;
  logic [DELAY_W-1:0]   dly_r;
  logic [DELAY_W-1:0]   per_r;
  logic [SLOT_W-1:0]    s_r;
  logic [SLOT_W-1:0]    h_r;
  logic [IDX_W-1:0]     cur_r, prev_r, steps_r;
  logic [SUM_W-1:0]     sum_r;
  logic [IDX_W-1:0]     res_slot_r;
  logic                 res_fired_r;
  logic [HANDLE_W-1:0]  res_handle_r;
  logic                 out_valid_r;
  out_beat_t            out_data_r;

  // Single read port of the table
  logic [SLOT_W-1:0]    rd_addr;
  logic [HANDLE_W-1:0]  rd_handle;
  logic [DELAY_W-1:0]   rd_delay;
  logic [DELAY_W-1:0]   rd_period;
  logic [IDX_W-1:0]     rd_succ;
  logic                 head_ok;

  always_comb begin
    case (state_r)
      S_WALK:   rd_addr = cur_r[SLOT_W-1:0];
      S_UNLINK: rd_addr = h_r;
      default:  rd_addr = head_r[SLOT_W-1:0];
    endcase
  end

  assign rd_handle = handle_mem[rd_addr];
  assign rd_delay  = delay_mem[rd_addr];
  assign rd_period = period_mem[rd_addr];
  assign rd_succ   = succ_mem[rd_addr];
  assign head_ok   = (head_r < NULL_CODE);

  // Lowest free slot
  logic                 free_found;
  logic [SLOT_W-1:0]    free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // Walk arithmetic: running sum and new relative delay
  logic [SUM_W-1:0]     nsum;
  logic [DELAY_W-1:0]   nd;
  logic                 walk_live;
  assign nsum      = sum_r + SUM_W'(rd_delay);
  assign nd        = dly_r - sum_r[DELAY_W-1:0];
  assign walk_live = (cur_r < NULL_CODE) && (steps_r < NULL_CODE);

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Table contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      head_r   <= NULL_CODE;
    end else begin
      case (state_r)
        S_EXEC: begin
          if (op_r == OP_ADD && free_found) begin
            in_use_r[free_idx]   <= 1'b1;
            handle_mem[free_idx] <= hd_r;
            period_mem[free_idx] <= per_r;
            succ_mem[free_idx]   <= NULL_CODE;
          end else if (op_r == OP_DISP && head_ok && rd_delay == '0 &&
                       rd_period != '0 && free_found) begin
            in_use_r[free_idx]   <= 1'b1;
            handle_mem[free_idx] <= rd_handle;
            period_mem[free_idx] <= rd_period;
            succ_mem[free_idx]   <= NULL_CODE;
          end else if (op_r == OP_TICK && head_ok && rd_delay != '0) begin
            delay_mem[head_r[SLOT_W-1:0]] <= rd_delay - 1'b1;
          end
        end
        S_WALK: begin
          if (walk_live && nsum > SUM_W'(dly_r)) begin
            // insert ahead of the current entry
            delay_mem[s_r]                 <= nd;
            succ_mem[s_r]                  <= cur_r;
            delay_mem[cur_r[SLOT_W-1:0]]   <= rd_delay - nd;
            if (prev_r == NULL_CODE) begin
              head_r <= IDX_W'(s_r);
            end else begin
              succ_mem[prev_r[SLOT_W-1:0]] <= IDX_W'(s_r);
            end
          end else if (!walk_live) begin
            // append at the tail or start the list
            delay_mem[s_r] <= nd;
            if (prev_r == NULL_CODE) begin
              head_r <= IDX_W'(s_r);
            end else begin
              succ_mem[prev_r[SLOT_W-1:0]] <= IDX_W'(s_r);
            end
          end
        end
        S_UNLINK: begin
          head_r      <= (rd_succ > NULL_CODE) ? NULL_CODE : rd_succ;
          in_use_r[h_r] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            op_r         <= q_head.op;
            hd_r         <= q_head.handle;
            dly_r        <= q_head.delay;
            per_r        <= q_head.period;
            res_slot_r   <= '0;
            res_fired_r  <= 1'b0;
            res_handle_r <= '0;
            state_r      <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_DONE;
          cur_r   <= head_r;
          prev_r  <= NULL_CODE;
          sum_r   <= '0;
          steps_r <= '0;
          s_r     <= free_idx;
          if (op_r == OP_ADD) begin
            res_slot_r <= free_found ? IDX_W'(free_idx) : NULL_CODE;
            if (free_found) begin
              state_r <= S_WALK;
            end
          end else if (op_r == OP_DISP && head_ok && rd_delay == '0) begin
            res_fired_r  <= 1'b1;
            res_handle_r <= rd_handle;
            h_r          <= head_r[SLOT_W-1:0];
            dly_r        <= rd_period;
            state_r      <= (rd_period != '0 && free_found) ? S_WALK : S_UNLINK;
          end
        end
        S_WALK: begin
          if (walk_live && nsum <= SUM_W'(dly_r)) begin
            sum_r   <= nsum;
            prev_r  <= cur_r;
            cur_r   <= rd_succ;
            steps_r <= steps_r + 1'b1;
          end else begin
            state_r <= (op_r == OP_DISP) ? S_UNLINK : S_DONE;
          end
        end
        S_UNLINK: state_r <= S_DONE;
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r             <= 1'b1;
            out_data_r.slot_index   <= SLOT_OUT_W'(res_slot_r);
            out_data_r.fired        <= res_fired_r;
            out_data_r.fired_handle <= res_handle_r;
            state_r                 <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/delta_list_task_timer_queue_top.sv */
// Top level of the delta-list timer queue: command front end feeding the table sequencer.
//
// A tick, an unknown command, an add to a full table and a dispatch that finds nothing
// due go from the queue through the execute state to the done state; an add that gets
// a slot first walks past every list entry whose due time is not later than the new
// task's (at most NUM_SLOTS entries); a due dispatch adds an unlink step and, for a
// periodic task with a slot free, the same walk as an add. A stalled result holds the
// sequencer in its done state. The walk reads one table entry per cycle through a single
// read port. A two-entry command queue keeps taking beats while the table is busy, until
// it fills, and a result register keeps the finished result while the next command runs.
`default_nettype none
module delta_list_task_timer_queue_top #(
  parameter int unsigned NUM_SLOTS = dltq_pkg::NUM_SLOTS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  dltq_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output dltq_pkg::out_beat_t  out_data
);
  import dltq_pkg::*;

  logic     q_valid;
  logic     q_pop;
  q_entry_t q_head;

  dltq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  dltq_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* sv/dltq_checker.sv */
// Port-level checker for the timer queue and its bind to the top level.
`default_nettype none
module dltq_checker #(
  parameter int unsigned NUM_SLOTS = dltq_pkg::NUM_SLOTS_DEF
) (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 out_valid,
  input wire                 out_stall,
  input dltq_pkg::out_beat_t out_data
);
  import dltq_pkg::*;

  // A stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // No released handle without a fire
  a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.fired |-> out_data.fired_handle == '0)
    else $error("handle reported without a fire");

  // A fire never reports a slot
  a_fire_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fired |-> out_data.slot_index == '0)
    else $error("slot reported on a dispatch");

  // Slot index never beyond the full code
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.slot_index <= SLOT_OUT_W'(NUM_SLOTS))
    else $error("slot index out of range");

endmodule

bind delta_list_task_timer_queue_top dltq_checker #(.NUM_SLOTS(NUM_SLOTS)) u_dltq_checker (.*);
`default_nettype wire

/* bench/tb_dltq_checker.sv */
// Checker for the delta-list timer queue: watches both channels, predicts and compares.
`timescale 1ns / 100ps
`default_nettype none
module tb_dltq_checker #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_stall,
  input  dltq_pkg::in_beat_t   in_data,
  input  wire                  out_valid,
  input  wire                  out_stall,
  input  dltq_pkg::out_beat_t  out_data,
  output int                   fail_count,
  output int                   pending_count
);
  import dltq_pkg::*;

  localparam logic [4:0] NIL = 5'(NUM_SLOTS);

  // Shadow copy of the slot table
  bit          used_q [NUM_SLOTS];
  logic [15:0] hnd_q  [NUM_SLOTS];
  logic [31:0] dly_q  [NUM_SLOTS];
  logic [31:0] per_q  [NUM_SLOTS];
  logic [4:0]  nxt_q  [NUM_SLOTS];
  logic [4:0]  head_q;

  out_beat_t due_results[$];
  int mismatches;

  assign pending_count = due_results.size();
  assign fail_count = mismatches;

  function automatic void release_slot(input int s);
    used_q[s] = 0;
    hnd_q[s] = '0;
    dly_q[s] = '0;
    per_q[s] = '0;
    nxt_q[s] = NIL;
  endfunction

  // Take the lowest free slot and link it in behind equal due times
  function automatic logic [4:0] place_task(input logic [15:0] h, input logic [31:0] d,
                                            input logic [31:0] p);
    int s;
    int cur;
    int prv;
    int steps;
    logic [63:0] sum;
    logic [31:0] nd;
    s = 0;
    while (s < NUM_SLOTS && used_q[s]) s++;
    if (s >= NUM_SLOTS) return NIL;
    used_q[s] = 1;
    hnd_q[s] = h;
    per_q[s] = p;
    nxt_q[s] = NIL;
    cur = head_q;
    prv = NUM_SLOTS;
    steps = 0;
    sum = '0;
    while (cur < NUM_SLOTS && steps < NUM_SLOTS) begin
      sum += dly_q[cur];
      if (sum > {32'd0, d}) break;
      prv = cur;
      cur = nxt_q[cur];
      steps++;
    end
    if (cur >= NUM_SLOTS || steps >= NUM_SLOTS) begin
      if (prv >= NUM_SLOTS) begin
        head_q = 5'(s);
        dly_q[s] = d;
      end else begin
        nxt_q[prv] = 5'(s);
        dly_q[s] = 32'({32'd0, d} - sum);
      end
    end else begin
      nd = 32'({32'd0, d} - (sum - dly_q[cur]));
      dly_q[s] = nd;
      nxt_q[s] = 5'(cur);
      if (prv >= NUM_SLOTS) head_q = 5'(s);
      else nxt_q[prv] = 5'(s);
      dly_q[cur] -= nd;
    end
    return 5'(s);
  endfunction

  function automatic out_beat_t predict_result(input in_beat_t b);
    out_beat_t r;
    int h;
    r = '0;
    case (b.command)
      CMD_TICK: begin
        if (head_q < NUM_SLOTS && dly_q[head_q] != 0) dly_q[head_q]--;
      end
      CMD_ADD: r.slot_index = place_task(b.task_handle, b.first_delay, b.repeat_period);
      CMD_DISP: begin
        h = head_q;
        if (h < NUM_SLOTS && dly_q[h] == 0) begin
          r.fired = 1'b1;
          r.fired_handle = hnd_q[h];
          if (per_q[h] != 0) void'(place_task(hnd_q[h], per_q[h], per_q[h]));
          head_q = nxt_q[h];
          if (head_q > NIL) head_q = NIL;
          release_slot(h);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Predict on accepted input beats, compare accepted output beats
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) release_slot(i);
      head_q = NIL;
      due_results.delete();
      mismatches = 0;
    end else begin
      if (in_valid && !in_stall) due_results.push_back(predict_result(in_data));
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", out_data);
        end else begin
          want = due_results.pop_front();
          if (out_data.slot_index !== want.slot_index || out_data.fired !== want.fired ||
              out_data.fired_handle !== want.fired_handle) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, got %p", want, out_data);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

/* bench/tb_delta_list_task_timer_queue_top.sv */
// Testbench top for the delta-list timer queue: stimulus, idling and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_delta_list_task_timer_queue_top;
  import dltq_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;
  int        fail_count;
  int        pending_count;
  int        quiet_cycles;
  bit        stim_done;

  localparam int QUIET_LIMIT = 20000;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  delta_list_task_timer_queue_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  tb_dltq_checker #(.NUM_SLOTS(NUM_SLOTS_DEF)) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one beat and hold it until accepted; no gap keeps valid up
  task automatic send_beat(input in_beat_t b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      in_data <= in_beat_t'({$urandom, $urandom, $urandom});
      repeat (g) @(negedge clk);
    end
    in_data <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic in_beat_t make_beat(input logic [1:0] c, input logic [15:0] h,
                                         input logic [31:0] d, input logic [31:0] p);
    in_beat_t b;
    b.command = c;
    b.task_handle = h;
    b.first_delay = d;
    b.repeat_period = p;
    return b;
  endfunction

  function automatic logic [31:0] pick_delay();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, 6);
    endcase
  endfunction

  // Random output stalls, with calm stretches
  initial begin
    int g;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < 30) begin
        g = gap_len();
        if (g > 0) begin
          out_stall <= 1'b1;
          repeat (g) @(negedge clk);
          out_stall <= 1'b0;
        end
      end else begin
        repeat ($urandom_range(0, 20)) @(negedge clk);
      end
    end
  end

  // Watchdog on accepted beats
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else if (stim_done && pending_count == 0) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_delta_list_task_timer_queue_top failed");
      $finish;
    end
  end

  initial begin
    in_beat_t b;
    int r;
    stim_done = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, extremes, zero handle, full table, periodic, unknown
    send_beat(make_beat(CMD_TICK, 16'h0, 32'h0, 32'h0));
    send_beat(make_beat(CMD_DISP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_beat(make_beat(CMD_UNKNOWN, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_beat(make_beat(CMD_ADD, 16'h0, 32'h0, 32'h0));
    send_beat(make_beat(CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_beat(make_beat(CMD_ADD, 16'h1234, 32'hFFFF_FFFF, 32'h0));
    send_beat(make_beat(CMD_ADD, 16'hA5A5, 32'd1, 32'd2));
    send_beat(make_beat(CMD_DISP, 16'h0, 32'h0, 32'h0));
    send_beat(make_beat(CMD_DISP, 16'h0, 32'h0, 32'h0));
    send_beat(make_beat(CMD_TICK, 16'h0, 32'h0, 32'h0));
    send_beat(make_beat(CMD_TICK, 16'h0, 32'h0, 32'h0));
    send_beat(make_beat(CMD_DISP, 16'h0, 32'h0, 32'h0));
    for (int i = 0; i < 15; i++)
      send_beat(make_beat(CMD_ADD, 16'(i + 1), 32'(i % 3), 32'd1));
    send_beat(make_beat(CMD_DISP, 16'h0, 32'h0, 32'h0));
    for (int i = 0; i < 20; i++) send_beat(make_beat(CMD_DISP, 16'h0, 32'h0, 32'h0));

    // Random: mostly small delays so tasks fall due, some table fills
    for (int n = 0; n < 1320; n++) begin
      r = $urandom_range(0, 99);
      b = in_beat_t'({$urandom, $urandom, $urandom});
      if (r < 35) b.command = CMD_ADD;
      else if (r < 65) b.command = CMD_TICK;
      else if (r < 97) b.command = CMD_DISP;
      else b.command = CMD_UNKNOWN;
      if (b.command == CMD_ADD) begin
        b.first_delay = pick_delay();
        b.repeat_period = ($urandom_range(0, 2) == 0) ? pick_delay() : 32'd0;
      end
      send_beat(b);
    end
    in_valid <= 1'b0;

    stim_done = 1'b1;
    wait (pending_count == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_delta_list_task_timer_queue_top passed");
    end else begin
      $display("tb_delta_list_task_timer_queue_top failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
sv/dltq_pkg.sv
sv/dltq_front.sv
sv/dltq_back.sv
sv/delta_list_task_timer_queue_top.sv
sv/dltq_checker.sv
bench/tb_dltq_checker.sv
bench/tb_delta_list_task_timer_queue_top.sv
